>>> hw/rtl/elfn_pkg.sv
// Shared types and constants for the ELF build-id note parser.
// Used by the front, queue, back and top-level modules; no dependencies.

package elfn_pkg;

   // Number of identifier bytes captured and emitted per run.
   localparam int ID_BYTES    = 20;
   localparam int IDX_W       = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
   localparam int CAP_W       = $clog2(ID_BYTES + 1);

   // Runs that may wait between the parser and the result emitter.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream payload widths.
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_DATA_W  = 32;

   // Configuration register indexes.
   localparam logic CSR_BIG_ENDIAN    = 1'b0;
   localparam logic CSR_REGION_LENGTH = 1'b1;

   // Note header layout and the note we look for.
   localparam int          HDR_BYTES     = 12;
   localparam logic [31:0] NT_BUILD_ID   = 32'd3;
   localparam logic [31:0] GNU_NAME_SIZE = 32'd4;
   localparam logic [3:0][7:0] GNU_NAME  = {8'h00, 8'h55, 8'h4E, 8'h47};

   // Low five bits of the final byte index of a run.
   localparam logic [4:0] LAST_INDEX5 = 5'((ID_BYTES - 1) % 32);

   // Everything the emitter needs to produce one result run.
   typedef struct packed {
      logic [ID_BYTES-1:0][7:0] id;
      logic                     found;
      logic [CAP_W-1:0]         len;
   } run_type;

   // Head of the run queue as seen by the emitter.
   typedef struct packed {
      logic    valid;
      run_type run;
   } q_head_type;

endpackage

>>> hw/rtl/elfn_front.sv
// Byte-level note parser: walks note headers, matches the GNU build-id note
// and captures its descriptor. Depends on elfn_pkg.

module elfn_front
   import elfn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        big_endian,
   input  logic [31:0] region_length,
   input  logic        in_accept,
   input  logic        start_req,
   input  logic [7:0]  data_byte,
   output logic        push,
   output run_type     push_run
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAME,
      PH_SKIP,
      PH_CAPTURE,
      PH_DONE
   } phase_type;

   phase_type                phase_ff, phase_in, cur_phase;
   logic [HDR_BYTES*8-1:0]   hdr_ff, hdr_in, cur_hdr, hdr_wr;
   logic [32:0]              count_ff, count_in, cur_count, count_inc;
   logic [31:0]              pos_ff, pos_in, cur_pos;
   logic                     name_ok_ff, name_ok_in, cur_name_ok;
   logic [ID_BYTES-1:0][7:0] store_ff, store_in, cur_store;
   logic [CAP_W-1:0]         cap_ff, cap_in, cur_cap;
   logic                     found_ff, found_in, cur_found;

   logic [31:0]      w0, w1, w2;
   logic [32:0]      pad0, pad1;
   logic             hdr_ok, name_chk, fin_ok, in_region, final_byte;
   logic [CAP_W-1:0] fin_cap;
   phase_type        fin_phase;
   logic             push_in;

   function automatic logic [31:0] hdr_word(input logic [HDR_BYTES*8-1:0] hb,
                                            input int w, input logic be);
      logic [31:0] raw;
      raw = hb[w*32 +: 32];
      hdr_word = be ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
   endfunction

   function automatic logic [32:0] pad4(input logic [31:0] v);
      pad4 = ({1'b0, v} + 33'd3) & ~33'd3;
   endfunction

   always_comb begin
      // A start marker clears the parser before this byte is taken.
      cur_phase   = start_req ? PH_HEADER : phase_ff;
      cur_hdr     = start_req ? '0 : hdr_ff;
      cur_count   = start_req ? '0 : count_ff;
      cur_pos     = start_req ? '0 : pos_ff;
      cur_name_ok = start_req ? 1'b0 : name_ok_ff;
      cur_store   = start_req ? '0 : store_ff;
      cur_cap     = start_req ? '0 : cap_ff;
      cur_found   = start_req ? 1'b0 : found_ff;

      count_inc  = cur_count + 33'd1;
      in_region  = cur_pos < region_length;
      final_byte = in_region && (cur_pos == region_length - 32'd1);

      hdr_wr = cur_hdr;
      if (cur_phase == PH_HEADER) begin
         for (int k = 0; k < HDR_BYTES; k++) begin
            if (cur_count == 33'(k)) begin
               hdr_wr[k*8 +: 8] = data_byte;
            end
         end
      end

      w0   = hdr_word(hdr_wr, 0, big_endian);
      w1   = hdr_word(hdr_wr, 1, big_endian);
      w2   = hdr_word(hdr_wr, 2, big_endian);
      pad0 = pad4(w0);
      pad1 = pad4(w1);

      hdr_ok   = (w2 == NT_BUILD_ID) && (w0 == GNU_NAME_SIZE);
      name_chk = cur_name_ok &&
                 !((cur_count < 33'd4) && (data_byte != GNU_NAME[cur_count[1:0]]));
      fin_ok   = (cur_phase == PH_HEADER) ? hdr_ok : name_chk;

      fin_cap = (pad1 < 33'(ID_BYTES)) ? pad1[CAP_W-1:0] : CAP_W'(ID_BYTES);
      if (fin_ok) begin
         fin_phase = (fin_cap == '0) ? PH_DONE : PH_CAPTURE;
      end else begin
         fin_phase = (pad1 == '0) ? PH_HEADER : PH_SKIP;
      end

      phase_in   = cur_phase;
      hdr_in     = cur_hdr;
      count_in   = cur_count;
      name_ok_in = cur_name_ok;
      store_in   = cur_store;
      cap_in     = cur_cap;
      found_in   = cur_found;
      pos_in     = (cur_pos == '1) ? cur_pos : cur_pos + 32'd1;

      if (in_region) begin
         case (cur_phase)
            PH_HEADER: begin
               if ((cur_count == '0) &&
                   ({1'b0, cur_pos} + 33'd12 >= {1'b0, region_length})) begin
                  phase_in = PH_DONE;
               end else begin
                  hdr_in   = hdr_wr;
                  count_in = count_inc;
                  if (count_inc >= 33'(HDR_BYTES)) begin
                     count_in   = '0;
                     name_ok_in = hdr_ok;
                     phase_in   = PH_NAME;
                     if (pad0 == '0) begin
                        if (fin_ok) begin
                           found_in = 1'b1;
                           cap_in   = fin_cap;
                        end
                        phase_in = fin_phase;
                     end
                  end
               end
            end
            PH_NAME: begin
               name_ok_in = name_chk;
               count_in   = count_inc;
               if (count_inc >= pad0) begin
                  count_in = '0;
                  if (fin_ok) begin
                     found_in = 1'b1;
                     cap_in   = fin_cap;
                  end
                  phase_in = fin_phase;
               end
            end
            PH_SKIP: begin
               count_in = count_inc;
               if (count_inc >= pad1) begin
                  count_in = '0;
                  phase_in = PH_HEADER;
               end
            end
            PH_CAPTURE: begin
               for (int k = 0; k < ID_BYTES; k++) begin
                  if (cur_count == 33'(k)) begin
                     store_in[k] = data_byte;
                  end
               end
               count_in = count_inc;
               if (count_inc >= 33'(cur_cap)) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end

      push_in = in_accept && final_byte;
   end

   assign push           = push_in;
   assign push_run.id    = store_in;
   assign push_run.found = found_in;
   assign push_run.len   = cap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_ff     <= '0;
         count_ff   <= '0;
         pos_ff     <= '0;
         name_ok_ff <= 1'b0;
         store_ff   <= '0;
         cap_ff     <= '0;
         found_ff   <= 1'b0;
      end else if (in_accept) begin
         phase_ff   <= phase_in;
         hdr_ff     <= hdr_in;
         count_ff   <= count_in;
         pos_ff     <= pos_in;
         name_ok_ff <= name_ok_in;
         store_ff   <= store_in;
         cap_ff     <= cap_in;
         found_ff   <= found_in;
      end
   end

endmodule

>>> hw/rtl/elfn_queue.sv
// Short queue of finished runs between the parser and the result emitter.
// Depends on elfn_pkg.

module elfn_queue
   import elfn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  run_type    push_run,
   input  logic       pop,
   output logic       full,
   output q_head_type head
);

   run_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.run   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

>>> hw/rtl/elfn_back.sv
// Result emitter: turns one queued run into ID_BYTES output words through
// a registered output stage. Depends on elfn_pkg.

module elfn_back
   import elfn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  q_head_type            head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  tvalid_ff, tvalid_in;
   logic [RSP_DATA_W-1:0] tdata_ff, tdata_in;
   logic                  tuser_ff, tuser_in;
   logic                  tlast_ff, tlast_in;
   logic                  load, at_end;
   logic [31:0]           idx_wide, len_wide;
   logic [7:0]            id_byte;

   assign load     = head.valid && (!tvalid_ff || rsp_tready);
   assign at_end   = (idx_ff == IDX_W'(ID_BYTES - 1));
   assign idx_wide = 32'(idx_ff);
   assign len_wide = 32'(head.run.len);
   assign id_byte  = (idx_wide < len_wide) ? head.run.id[idx_ff] : 8'h00;
   assign pop      = load && at_end;

   always_comb begin
      idx_in    = idx_ff;
      tvalid_in = tvalid_ff;
      tdata_in  = tdata_ff;
      tuser_in  = tuser_ff;
      tlast_in  = tlast_ff;
      if (load) begin
         tvalid_in = 1'b1;
         tdata_in  = {6'b0, len_wide[4:0], idx_wide[4:0], id_byte};
         tuser_in  = head.run.found;
         tlast_in  = at_end;
         idx_in    = at_end ? '0 : idx_ff + 1'b1;
      end else if (rsp_tready) begin
         tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         tvalid_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         tvalid_ff <= tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      tdata_ff <= tdata_in;
      tuser_ff <= tuser_in;
      tlast_ff <= tlast_in;
   end

   assign rsp_tvalid = tvalid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tuser  = tuser_ff;
   assign rsp_tlast  = tlast_ff;

endmodule

>>> hw/rtl/elf_note_build_id_parser.sv
// Top level of the ELF note build-id parser: configuration registers,
// byte parser, run queue and result emitter. Depends on elfn_pkg.

// The block takes an ELF note region one byte per word on the req_ channel
// and looks for the first note of type 3 named "GNU" (with its NUL). Header
// words are read in the byte order set by the big_endian register, and only
// region_length bytes count; bytes past the end are dropped without a
// result, and a word with the start flag in req_tuser begins a new region.
// When the last region byte arrives, one run of ID_BYTES (20) words leaves
// on the rsp_ channel: the identifier byte, its index, the found flag and
// the captured length, with tlast on the final word. The parser takes one
// byte every cycle while the queue has room. Each run leaves the emitter
// through its registered output stage, and up to two finished runs wait
// in a queue between parser and emitter, so req_tready drops only while
// both queue slots are taken. There is no clearing pass after reset.
// Configuration writes belong to idle periods, when no result is still pending.

module elf_note_build_id_parser
   import elfn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Configuration write port.
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // Region bytes in.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] data_byte
   input  logic                  req_tuser,  // [0] start_req
   // Identifier words out.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [7:0] id_byte, [12:8] byte_index,
                                             // [17:13] id_length, [23:18] zero
   output logic                  rsp_tuser,  // [0] found
   output logic                  rsp_tlast   // last word of the run
);

   logic        big_endian_ff, big_endian_in;
   logic [31:0] region_length_ff, region_length_in;

   logic        in_accept;
   logic        q_push, q_pop, q_full;
   run_type     q_push_run;
   q_head_type  q_head;

   // Configuration registers, written without handshake.
   always_comb begin
      big_endian_in    = big_endian_ff;
      region_length_in = region_length_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BIG_ENDIAN:    big_endian_in    = csr_wdata[0];
            CSR_REGION_LENGTH: region_length_in = csr_wdata[31:0];
            default:           big_endian_in    = big_endian_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff    <= 1'b0;
         region_length_ff <= '0;
      end else begin
         big_endian_ff    <= big_endian_in;
         region_length_ff <= region_length_in;
      end
   end

   // The parser takes a byte whenever the run queue is not full.
   assign req_tready = !q_full;
   assign in_accept  = req_tvalid && req_tready;

   elfn_front u_front (
      .clock         (clock),
      .reset         (reset),
      .big_endian    (big_endian_ff),
      .region_length (region_length_ff),
      .in_accept     (in_accept),
      .start_req     (req_tuser),
      .data_byte     (req_tdata[7:0]),
      .push          (q_push),
      .push_run      (q_push_run)
   );

   elfn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_run (q_push_run),
      .pop      (q_pop),
      .full     (q_full),
      .head     (q_head)
   );

   elfn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A run without a build-id note carries zero length and zero bytes.
   a_not_found_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[17:13] == 5'd0 && rsp_tdata[7:0] == 8'd0)
      else $error("word of a run without a note carries data");

   // The run ends exactly on its final byte index.
   a_last_index : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[12:8] == LAST_INDEX5)
      else $error("tlast on a word that is not the final index");

   // Inside a run the next word follows at once and keeps the found flag.
   a_run_gapless : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tuser == $past(rsp_tuser))
      else $error("gap or found change inside a run");

endmodule
